// ===== design/dual_pool_first_fit_allocator_defines.svh =====
`ifndef DUAL_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define DUAL_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define DPFFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpffa: assertion failed");

// next-cycle implication
`define DPFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpffa: assertion failed");

`endif

// ===== design/dpffa_pkg.sv =====
package dpffa_pkg;

  localparam int unsigned FREE_DEPTH_DEF = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [DATA_W-1:0] VERTEX_CAP_RST = 32'd67108864;
  localparam logic [DATA_W-1:0] META_CAP_RST   = 32'd16777216;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_CAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_META_CAP   = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 3'd0,
    ST_VERTEX_EXHAUSTED = 3'd1,
    ST_META_EXHAUSTED   = 3'd2,
    ST_LIST_FULL        = 3'd3,
    ST_IGNORED          = 3'd4
  } status_e;

  typedef struct packed {
    logic clr;
    logic cmp;
    logic commit;
    logic move;
    logic append;
  } pool_cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
    logic full;
  } pool_stat_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic commit;
    logic move;
    logic release_req;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic alloc_ok;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/dpffa_pool.sv =====
module dpffa_pool
  import dpffa_pkg::*;
#(
  parameter int unsigned FREE_DEPTH = FREE_DEPTH_DEF,
  localparam int unsigned IDX_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(FREE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pool_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]  scan_addr_i,
  input  logic [CNT_W-1:0]  cmp_idx_i,
  input  logic [DATA_W-1:0] bytes_i,
  input  logic [DATA_W-1:0] start_i,
  input  logic [DATA_W-1:0] cap_i,
  output pool_stat_t        stat_o,
  output logic [DATA_W-1:0] offset_o
);

  logic [2*DATA_W-1:0] mem_q [FREE_DEPTH];
  logic [2*DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] bump_q, bump_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [DATA_W-1:0] hit_off_q;
  logic [DATA_W-1:0] hit_size_q;

  logic [DATA_W-1:0]   rd_off, rd_size;
  logic [CNT_W-1:0]    last;
  logic [IDX_W-1:0]    raddr;
  logic                found;
  logic                used_up;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [2*DATA_W-1:0] wdata;
  logic [DATA_W:0]     bump_end;

  assign rd_off  = rdata_q[2*DATA_W-1:DATA_W];
  assign rd_size = rdata_q[DATA_W-1:0];
  assign last    = count_q - CNT_W'(1);
  assign raddr   = cmd_i.commit ? last[IDX_W-1:0] : scan_addr_i;
  assign used_up = (hit_size_q == bytes_i);
  assign found   = cmd_i.cmp && !hit_q && (cmp_idx_i < count_q) && (rd_size >= bytes_i);

  assign bump_end = {1'b0, bump_q} + {1'b0, bytes_i};

  assign stat_o.done = hit_q || (cmp_idx_i >= count_q);
  assign stat_o.ok   = hit_q || (bump_end <= {1'b0, cap_i});
  assign stat_o.full = (count_q >= CNT_W'(FREE_DEPTH));
  assign offset_o    = hit_q ? hit_off_q : bump_q;

  always_comb begin
    we      = 1'b0;
    waddr   = hit_idx_q;
    wdata   = {hit_off_q + bytes_i, hit_size_q - bytes_i};
    count_d = count_q;
    bump_d  = bump_q;
    hit_d   = hit_q;
    if (cmd_i.clr) begin
      hit_d = 1'b0;
    end else if (found) begin
      hit_d = 1'b1;
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        we = !used_up;
      end else begin
        bump_d = bump_q + bytes_i;
      end
    end
    if (cmd_i.move && hit_q && used_up) begin
      we      = 1'b1;
      wdata   = rdata_q;
      count_d = last;
    end
    if (cmd_i.append) begin
      we      = 1'b1;
      waddr   = count_q[IDX_W-1:0];
      wdata   = {start_i, bytes_i};
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bump_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      bump_q  <= bump_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (found) begin
      hit_idx_q  <= cmp_idx_i[IDX_W-1:0];
      hit_off_q  <= rd_off;
      hit_size_q <= rd_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

// ===== design/dpffa_datapath.sv =====
module dpffa_datapath
  import dpffa_pkg::*;
#(
  parameter int unsigned FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [DATA_W-1:0]    vertex_bytes_i,
  input  logic [DATA_W-1:0]    meta_bytes_i,
  input  logic [DATA_W-1:0]    vertex_start_i,
  input  logic [DATA_W-1:0]    meta_start_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [DATA_W-1:0]    vtx_offset_o,
  output logic [DATA_W-1:0]    meta_offset_o
);

  localparam int unsigned IDX_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FREE_DEPTH + 1);

  logic [DATA_W-1:0] vbytes_q, mbytes_q, vstart_q, mstart_q;
  logic [DATA_W-1:0] vcap_q, mcap_q;
  logic [CNT_W-1:0]  scan_idx_q, cmp_cnt_q;
  logic              pipe_v_q;
  logic              out_valid_q;
  status_e           res_status_q;
  logic [DATA_W-1:0] res_voff_q, res_moff_q;

  pool_cmd_t  v_cmd, m_cmd;
  pool_stat_t v_stat, m_stat;
  logic [DATA_W-1:0] v_off, m_off;
  logic       issue;
  logic       alloc_ok;
  status_e    alloc_status, rel_status;
  logic       rel_ok;

  assign issue = cmd_i.scan && (scan_idx_q < CNT_W'(FREE_DEPTH));

  assign alloc_ok = v_stat.ok && m_stat.ok;
  always_comb begin
    if (!v_stat.ok) begin
      alloc_status = ST_VERTEX_EXHAUSTED;
    end else if (!m_stat.ok) begin
      alloc_status = ST_META_EXHAUSTED;
    end else begin
      alloc_status = ST_OK;
    end
    if (vbytes_q == '0) begin
      rel_status = ST_IGNORED;
    end else if (v_stat.full || ((mbytes_q != '0) && m_stat.full)) begin
      rel_status = ST_LIST_FULL;
    end else begin
      rel_status = ST_OK;
    end
  end
  assign rel_ok = (rel_status == ST_OK);

  always_comb begin
    v_cmd.clr    = cmd_i.load;
    v_cmd.cmp    = cmd_i.scan && pipe_v_q;
    v_cmd.commit = cmd_i.commit;
    v_cmd.move   = cmd_i.move;
    v_cmd.append = cmd_i.release_req && rel_ok;
    m_cmd        = v_cmd;
    m_cmd.append = cmd_i.release_req && rel_ok && (mbytes_q != '0);
  end

  dpffa_pool #(
    .FREE_DEPTH(FREE_DEPTH)
  ) u_vertex_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (v_cmd),
    .scan_addr_i(scan_idx_q[IDX_W-1:0]),
    .cmp_idx_i  (cmp_cnt_q),
    .bytes_i    (vbytes_q),
    .start_i    (vstart_q),
    .cap_i      (vcap_q),
    .stat_o     (v_stat),
    .offset_o   (v_off)
  );

  dpffa_pool #(
    .FREE_DEPTH(FREE_DEPTH)
  ) u_meta_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (m_cmd),
    .scan_addr_i(scan_idx_q[IDX_W-1:0]),
    .cmp_idx_i  (cmp_cnt_q),
    .bytes_i    (mbytes_q),
    .start_i    (mstart_q),
    .cap_i      (mcap_q),
    .stat_o     (m_stat),
    .offset_o   (m_off)
  );

  assign stat_o.scan_done = v_stat.done && m_stat.done;
  assign stat_o.alloc_ok  = alloc_ok;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q      <= VERTEX_CAP_RST;
      mcap_q      <= META_CAP_RST;
      scan_idx_q  <= '0;
      cmp_cnt_q   <= '0;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VERTEX_CAP: vcap_q <= cfg_data_i;
          CFG_META_CAP:   mcap_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        cmp_cnt_q  <= '0;
        pipe_v_q   <= 1'b0;
      end else begin
        pipe_v_q <= issue;
        if (issue) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        if (cmd_i.scan && pipe_v_q) begin
          cmp_cnt_q <= cmp_cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vbytes_q <= vertex_bytes_i;
      mbytes_q <= meta_bytes_i;
      vstart_q <= vertex_start_i;
      mstart_q <= meta_start_i;
    end
    if (cmd_i.decide) begin
      res_status_q <= alloc_status;
      res_voff_q   <= alloc_ok ? v_off : '0;
      res_moff_q   <= alloc_ok ? m_off : '0;
    end
    if (cmd_i.release_req) begin
      res_status_q <= rel_status;
      res_voff_q   <= '0;
      res_moff_q   <= '0;
    end
    if (cmd_i.publish) begin
      status_o      <= res_status_q;
      vtx_offset_o  <= res_voff_q;
      meta_offset_o <= res_moff_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/dpffa_ctrl.sv =====
module dpffa_ctrl
  import dpffa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     mode_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMMIT,
    S_MOVE,
    S_RELEASE,
    S_PUBLISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mode_i ? S_RELEASE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = stat_i.alloc_ok ? S_COMMIT : S_PUBLISH;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_PUBLISH;
      end
      S_RELEASE: begin
        cmd_o.release_req = 1'b1;
        state_d           = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/dual_pool_first_fit_allocator.sv =====
// Allocate: after acceptance both free lists are scanned in parallel, one entry per cycle, up to
//   FREE_DEPTH entries, until both scans are done; the request is then decided, committed and
//   moved, then published; a rejected request skips commit and move. One read port per list.
// Release: entries appended if room, status set, then published. One transaction in flight; the
//   next is taken in the cycle after its result is registered, later while the output stalls.
// Reset: counts, bump pointers clear, capacities load defaults; list memory is not cleared.
`include "dual_pool_first_fit_allocator_defines.svh"

module dual_pool_first_fit_allocator
  import dpffa_pkg::*;
#(
  parameter int unsigned FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [DATA_W-1:0]    vertex_bytes_i,
  input  logic [DATA_W-1:0]    meta_bytes_i,
  input  logic [DATA_W-1:0]    vertex_start_i,
  input  logic [DATA_W-1:0]    meta_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [DATA_W-1:0]    vtx_offset_o,
  output logic [DATA_W-1:0]    meta_offset_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  dpffa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  dpffa_datapath #(
    .FREE_DEPTH(FREE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .vertex_bytes_i(vertex_bytes_i),
    .meta_bytes_i  (meta_bytes_i),
    .vertex_start_i(vertex_start_i),
    .meta_start_i  (meta_start_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .vtx_offset_o  (vtx_offset_o),
    .meta_offset_o (meta_offset_o)
  );

  `DPFFA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `DPFFA_ASSERT_NEXT(a_publish_valid, clk_i, rst_ni, dp_cmd.publish, out_valid_o)
  `DPFFA_ASSERT_NOW(a_fail_zero_off, clk_i, rst_ni,
    out_valid_o && (status_o != ST_OK), (vtx_offset_o == '0) && (meta_offset_o == '0))

endmodule

// ===== tb/sv/dpffa_test_pkg.sv =====
package dpffa_test_pkg;
  import dpffa_pkg::*;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam int POOL_VERTEX = 0;
  localparam int POOL_META   = 1;

  localparam int unsigned LIST_DEPTH   = FREE_DEPTH_DEF;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned GRANT_KEEP   = 48;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] vertex_bytes;
    logic [DATA_W-1:0] meta_bytes;
    logic [DATA_W-1:0] vertex_start;
    logic [DATA_W-1:0] meta_start;
  } alloc_req_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] vtx_offset;
    logic [DATA_W-1:0] meta_offset;
  } alloc_result_t;

  typedef struct packed {
    logic [DATA_W-1:0] vertex_start;
    logic [DATA_W-1:0] vertex_bytes;
    logic [DATA_W-1:0] meta_start;
    logic [DATA_W-1:0] meta_bytes;
  } grant_t;

  class pool_scoreboard;
    logic [DATA_W-1:0] blk_off  [2][LIST_DEPTH];
    logic [DATA_W-1:0] blk_size [2][LIST_DEPTH];
    int unsigned       blk_count [2];
    logic [DATA_W-1:0] bump [2];
    logic [DATA_W-1:0] capacity [2];
    alloc_result_t     expected_q [$];
    grant_t            granted_q [$];
    int unsigned       status_hits [5];
    int unsigned       checked;
    int unsigned       errors;

    function new();
      capacity[POOL_VERTEX] = VERTEX_CAP_RST;
      capacity[POOL_META]   = META_CAP_RST;
      blk_count   = '{0, 0};
      bump        = '{32'd0, 32'd0};
      status_hits = '{default: 0};
      checked     = 0;
      errors      = 0;
    endfunction

    function void set_capacity(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      if (idx == CFG_VERTEX_CAP) begin
        capacity[POOL_VERTEX] = value;
      end else if (idx == CFG_META_CAP) begin
        capacity[POOL_META] = value;
      end
    endfunction

    // first fit in the list, else the bump pointer if it stays within capacity
    function void find_fit(int p, logic [DATA_W-1:0] bytes, output bit ok,
                           output bit from_list, output int idx,
                           output logic [DATA_W-1:0] off);
      ok        = 1'b0;
      from_list = 1'b0;
      idx       = 0;
      off       = '0;
      for (int i = 0; i < int'(blk_count[p]); i++) begin
        if (blk_size[p][i] >= bytes) begin
          ok        = 1'b1;
          from_list = 1'b1;
          idx       = i;
          off       = blk_off[p][i];
          return;
        end
      end
      if (({1'b0, bump[p]} + {1'b0, bytes}) <= {1'b0, capacity[p]}) begin
        ok  = 1'b1;
        off = bump[p];
      end
    endfunction

    function void take(int p, bit from_list, int idx, logic [DATA_W-1:0] bytes);
      int unsigned last;
      if (from_list) begin
        blk_off[p][idx]  = blk_off[p][idx] + bytes;
        blk_size[p][idx] = blk_size[p][idx] - bytes;
        if (blk_size[p][idx] == '0) begin
          last             = blk_count[p] - 1;
          blk_off[p][idx]  = blk_off[p][last];
          blk_size[p][idx] = blk_size[p][last];
          blk_count[p]     = last;
        end
      end else begin
        bump[p] = bump[p] + bytes;
      end
    endfunction

    function void append(int p, logic [DATA_W-1:0] start, logic [DATA_W-1:0] bytes);
      blk_off[p][blk_count[p]]  = start;
      blk_size[p][blk_count[p]] = bytes;
      blk_count[p]++;
    endfunction

    function void note_input(alloc_req_t req);
      alloc_result_t     exp;
      grant_t            grant;
      bit                v_ok, v_list, m_ok, m_list;
      int                v_idx, m_idx;
      logic [DATA_W-1:0] v_off, m_off;
      exp.status      = ST_OK;
      exp.vtx_offset  = '0;
      exp.meta_offset = '0;
      if (req.mode == MODE_ALLOC) begin
        find_fit(POOL_VERTEX, req.vertex_bytes, v_ok, v_list, v_idx, v_off);
        if (!v_ok) begin
          exp.status = ST_VERTEX_EXHAUSTED;
        end else begin
          find_fit(POOL_META, req.meta_bytes, m_ok, m_list, m_idx, m_off);
          if (!m_ok) begin
            exp.status = ST_META_EXHAUSTED;
          end else begin
            take(POOL_VERTEX, v_list, v_idx, req.vertex_bytes);
            take(POOL_META, m_list, m_idx, req.meta_bytes);
            exp.vtx_offset  = v_off;
            exp.meta_offset = m_off;
            if (req.vertex_bytes != '0) begin
              grant = '{v_off, req.vertex_bytes, m_off, req.meta_bytes};
              granted_q.push_back(grant);
              if (granted_q.size() > GRANT_KEEP) void'(granted_q.pop_front());
            end
          end
        end
      end else if (req.vertex_bytes == '0) begin
        exp.status = ST_IGNORED;
      end else if (blk_count[POOL_VERTEX] >= LIST_DEPTH ||
                   (req.meta_bytes != '0 && blk_count[POOL_META] >= LIST_DEPTH)) begin
        exp.status = ST_LIST_FULL;
      end else begin
        append(POOL_VERTEX, req.vertex_start, req.vertex_bytes);
        if (req.meta_bytes != '0) append(POOL_META, req.meta_start, req.meta_bytes);
      end
      status_hits[int'(exp.status)]++;
      expected_q.push_back(exp);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%t transaction %0d: %s", $time, checked, what);
    endfunction

    function void check(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] vo,
                        logic [DATA_W-1:0] mo);
      alloc_result_t exp;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status %0d vertex %h meta %h", st, vo, mo));
        return;
      end
      exp = expected_q.pop_front();
      if (st !== exp.status)
        report($sformatf("status expected %0d got %0d", exp.status, st));
      if (vo !== exp.vtx_offset)
        report($sformatf("vertex offset expected %h got %h", exp.vtx_offset, vo));
      if (mo !== exp.meta_offset)
        report($sformatf("meta offset expected %h got %h", exp.meta_offset, mo));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit failed();
      return (errors != 0) || (expected_q.size() != 0);
    endfunction
  endclass

endpackage

// ===== tb/sv/dual_pool_first_fit_allocator_test.sv =====
module dual_pool_first_fit_allocator_test;
  import dpffa_pkg::*;
  import dpffa_test_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_LEN    = 500;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 mode_i;
  logic [DATA_W-1:0]    vertex_bytes_i;
  logic [DATA_W-1:0]    meta_bytes_i;
  logic [DATA_W-1:0]    vertex_start_i;
  logic [DATA_W-1:0]    meta_start_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  status_o;
  logic [DATA_W-1:0]    vtx_offset_o;
  logic [DATA_W-1:0]    meta_offset_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  pool_scoreboard sb;
  int unsigned    cycle_cnt = 0;
  int unsigned    hold_left = 0;
  bit             long_hold_done = 1'b0;
  logic [15:0]    stall_pat = '1;
  logic [5:0]     pat_tick = '0;

  dual_pool_first_fit_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .vertex_bytes_i  (vertex_bytes_i),
    .meta_bytes_i    (meta_bytes_i),
    .vertex_start_i  (vertex_start_i),
    .meta_start_i    (meta_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .vtx_offset_o    (vtx_offset_o),
    .meta_offset_o   (meta_offset_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("dual_pool_first_fit_allocator test failed");
      $finish;
    end
  end

  // result side: check, then pick next ready value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(status_o, vtx_offset_o, meta_offset_o);
    pat_tick = pat_tick + 1'b1;
    if (pat_tick == '0) begin
      case ($urandom_range(3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom);
      endcase
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && sb.checked >= HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left      = HOLD_LEN;
      out_ready_i    <= 1'b0;
    end else begin
      out_ready_i <= stall_pat[pat_tick[3:0]];
    end
  end

  task automatic send(input alloc_req_t req);
    in_valid_i     <= 1'b1;
    mode_i         <= req.mode;
    vertex_bytes_i <= req.vertex_bytes;
    meta_bytes_i   <= req.meta_bytes;
    vertex_start_i <= req.vertex_start;
    meta_start_i   <= req.meta_start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(req);
  endtask

  task automatic do_alloc(input logic [DATA_W-1:0] vb, input logic [DATA_W-1:0] mb);
    send('{MODE_ALLOC, vb, mb, $urandom, $urandom});
  endtask

  task automatic do_release(input logic [DATA_W-1:0] vs, input logic [DATA_W-1:0] vb,
                            input logic [DATA_W-1:0] ms, input logic [DATA_W-1:0] mb);
    send('{MODE_RELEASE, vb, mb, vs, ms});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_caps(input logic [DATA_W-1:0] vcap, input logic [DATA_W-1:0] mcap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VERTEX_CAP;
    cfg_data_i <= vcap;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_META_CAP;
    cfg_data_i <= mcap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_capacity(CFG_VERTEX_CAP, vcap);
    sb.set_capacity(CFG_META_CAP, mcap);
  endtask

  function automatic logic [DATA_W-1:0] headroom(logic [DATA_W-1:0] base, int unsigned extra);
    logic [DATA_W:0] sum;
    sum = {1'b0, base} + extra;
    return sum[DATA_W] ? '1 : sum[DATA_W-1:0];
  endfunction

  function automatic alloc_req_t make_alloc();
    alloc_req_t  req;
    int unsigned n;
    req.mode         = MODE_ALLOC;
    req.vertex_start = $urandom;
    req.meta_start   = $urandom;
    case ($urandom_range(9))
      0: begin
        req.vertex_bytes = $urandom_range(1) ? 32'd0 : $urandom_range(1, 64);
        req.meta_bytes   = $urandom_range(1) ? 32'd0 : $urandom_range(1, 64);
      end
      1, 2: begin
        n = sb.blk_count[POOL_VERTEX];
        req.vertex_bytes = (n > 0) ? sb.blk_size[POOL_VERTEX][$urandom_range(n - 1)]
                                   : $urandom_range(1, 256);
        n = sb.blk_count[POOL_META];
        req.meta_bytes   = (n > 0) ? sb.blk_size[POOL_META][$urandom_range(n - 1)]
                                   : $urandom_range(0, 256);
      end
      8: begin
        req.vertex_bytes = $urandom_range(1, 1 << 20);
        req.meta_bytes   = $urandom_range(0, 1 << 20);
      end
      9: begin
        req.vertex_bytes = $urandom;
        req.meta_bytes   = $urandom;
      end
      default: begin
        req.vertex_bytes = $urandom_range(1, 4096);
        req.meta_bytes   = $urandom_range(0, 1024);
      end
    endcase
    return req;
  endfunction

  // hand back an earlier grant when one is outstanding
  function automatic alloc_req_t make_release();
    alloc_req_t req;
    grant_t     grant;
    int unsigned k;
    req.mode = MODE_RELEASE;
    if (sb.granted_q.size() > 0) begin
      k     = $urandom_range(sb.granted_q.size() - 1);
      grant = sb.granted_q[k];
      sb.granted_q.delete(k);
      req.vertex_start = grant.vertex_start;
      req.vertex_bytes = grant.vertex_bytes;
      req.meta_start   = grant.meta_start;
      req.meta_bytes   = grant.meta_bytes;
    end else begin
      req.vertex_start = $urandom;
      req.vertex_bytes = $urandom_range(1, 8192);
      req.meta_start   = $urandom;
      req.meta_bytes   = ($urandom_range(4) == 0) ? 32'd0 : $urandom_range(1, 2048);
    end
    return req;
  endfunction

  function automatic alloc_req_t make_noise();
    alloc_req_t req;
    req.mode         = 1'($urandom_range(1));
    req.vertex_bytes = $urandom_range(1) ? $urandom : $urandom_range(255);
    req.meta_bytes   = $urandom_range(1) ? $urandom : $urandom_range(255);
    req.vertex_start = $urandom;
    req.meta_start   = $urandom;
    return req;
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned alloc_pct,
                           input int unsigned release_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < int'(burst) && sent < count; k++) begin
        pick = $urandom_range(99);
        if (pick < alloc_pct) send(make_alloc());
        else if (pick < alloc_pct + release_pct) send(make_release());
        else send(make_noise());
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_ALLOC;
    vertex_bytes_i = '0;
    meta_bytes_i   = '0;
    vertex_start_i = '0;
    meta_start_i   = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_VERTEX_CAP;
    cfg_data_i     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default capacities
    do_alloc(32'd0, 32'd0);
    do_alloc(32'h100, 32'h40);
    do_alloc(32'hFFFF_FFFF, 32'd1);
    do_alloc(32'h10, 32'hFFFF_FFFF);
    do_alloc(VERTEX_CAP_RST - 32'h100, 32'd0);
    do_alloc(32'd1, 32'd0);
    do_release(32'h1234, 32'd0, 32'h5678, 32'd5);
    do_release(32'h1000, 32'h200, 32'hFFFF_FFFF, 32'd0);
    do_release(32'hFFFF_FFF0, 32'h20, 32'h5000, 32'h80);
    do_release(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_alloc(32'd0, 32'd0);
    do_alloc(32'h200, 32'h80);
    do_alloc(32'h18, 32'h10);
    do_alloc(32'hFFFF_FFFF, 32'd0);
    do_alloc(32'hFFFF_FFE7, 32'hFFFF_FFEF);
    do_alloc(32'h20, 32'h20);
    do_alloc(32'd0, 32'd0);
    drain();

    write_caps('1, '1);
    run_phase(320, 50, 35);
    write_caps('0, '0);
    run_phase(280, 25, 60);
    write_caps(headroom(sb.bump[POOL_VERTEX], 1 << 16), headroom(sb.bump[POOL_META], 1 << 14));
    run_phase(380, 60, 25);
    write_caps($urandom, $urandom);
    run_phase(400, 45, 40);

    repeat (40) @(posedge clk_i);
    $display("%0d transactions: ok %0d, vertex exhausted %0d, meta exhausted %0d",
             sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_VERTEX_EXHAUSTED],
             sb.status_hits[ST_META_EXHAUSTED]);
    $display("list full %0d, release ignored %0d, five capacity settings, long output stall %0d",
             sb.status_hits[ST_LIST_FULL], sb.status_hits[ST_IGNORED], long_hold_done);
    if (!sb.failed()) begin
      $display("dual_pool_first_fit_allocator test passed");
    end else begin
      $display("dual_pool_first_fit_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== dual_pool_first_fit_allocator.f =====
+incdir+design
design/dpffa_pkg.sv
design/dpffa_pool.sv
design/dpffa_datapath.sv
design/dpffa_ctrl.sv
design/dual_pool_first_fit_allocator.sv
tb/sv/dpffa_test_pkg.sv
tb/sv/dual_pool_first_fit_allocator_test.sv
